### hdl/blsa_pkg.sv
// shared types and constants for the button lock setpoint adjuster
`timescale 1ns / 1ps
`default_nettype none
package blsa_pkg;

    localparam int TimeW   = 32;
    localparam int HoldW   = 16;
    localparam int ScrollW = 16;
    localparam int StepW   = 8;
    localparam int SetW    = 9;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 32;

    localparam logic [HoldW-1:0]   UnlockHoldRst = HoldW'(3000);
    localparam logic [TimeW-1:0]   AutoLockRst   = TimeW'(60000);
    localparam logic [ScrollW-1:0] ScrollRst     = ScrollW'(250);
    localparam logic [StepW-1:0]   StepRst       = StepW'(2);
    localparam logic [SetW-1:0]    MaxSetRst     = SetW'(420);
    localparam logic [SetW-1:0]    MinSetRst     = SetW'(150);

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgUnlockHold = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgAutoLock   = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgScroll     = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgStep       = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] CfgMaxSet     = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] CfgMinSet     = CfgIdxW'(5);

    // operation codes
    localparam logic OpSample = 1'b0;
    localparam logic OpLoad   = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [TimeW-1:0] now_ms;
        logic             btn_up;
        logic             btn_down;
        logic [SetW-1:0]  load_value;
    } t_in_word;

    typedef struct packed {
        logic [SetW-1:0] setpoint;
        logic            unlocked;
        logic            adjusted;
    } t_out_word;

endpackage
`default_nettype wire

### hdl/button_lock_setpoint_adjuster_top.sv
// pipeline: an accepted word passes the input register, then the result register
// throughput: one word per cycle while the result is taken; the panel state is updated as each
// word leaves the input register, so the next word in the input register always sees it
// reset: synchronous active low; clears lock, timers, setpoint, pipeline valids and
// returns the configuration registers to their default values
`timescale 1ns / 1ps
`default_nettype none
module button_lock_setpoint_adjuster_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire blsa_pkg::t_in_word    i_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output blsa_pkg::t_out_word        o_out,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [blsa_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire [blsa_pkg::CfgDatW-1:0] i_cfg_data
);
    import blsa_pkg::*;

    // configuration
    logic [HoldW-1:0]   r_unlock_hold;
    logic [TimeW-1:0]   r_auto_lock;
    logic [ScrollW-1:0] r_scroll_delay;
    logic [StepW-1:0]   r_step;
    logic [SetW-1:0]    r_max_set;
    logic [SetW-1:0]    r_min_set;

    // panel state
    logic             r_unlock;
    logic [TimeW-1:0] r_last_activity;
    logic [TimeW-1:0] r_hold_start;
    logic [TimeW-1:0] r_last_scroll;
    logic [SetW-1:0]  r_setpoint;

    // pipeline
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      advance;

    logic             n_unlock;
    logic [TimeW-1:0] n_last_activity;
    logic [TimeW-1:0] n_hold_start;
    logic [TimeW-1:0] n_last_scroll;
    logic [SetW-1:0]  n_setpoint;
    logic             n_adjusted;

    logic             idle_expired;
    logic             hold_done;
    logic             scroll_due;
    logic             still_unlocked;
    logic             btn_any;
    logic             btn_both;
    logic signed [SetW+1:0] step_sum;
    logic [SetW-1:0]  step_result;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_hold  <= UnlockHoldRst;
            r_auto_lock    <= AutoLockRst;
            r_scroll_delay <= ScrollRst;
            r_step         <= StepRst;
            r_max_set      <= MaxSetRst;
            r_min_set      <= MinSetRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgUnlockHold: r_unlock_hold  <= i_cfg_data[HoldW-1:0];
                CfgAutoLock:   r_auto_lock    <= i_cfg_data[TimeW-1:0];
                CfgScroll:     r_scroll_delay <= i_cfg_data[ScrollW-1:0];
                CfgStep:       r_step         <= i_cfg_data[StepW-1:0];
                CfgMaxSet:     r_max_set      <= i_cfg_data[SetW-1:0];
                CfgMinSet:     r_min_set      <= i_cfg_data[SetW-1:0];
                default: ;
            endcase
        end
    end

    // wrapped time differences, each one subtract and compare
    assign idle_expired = (r_in.now_ms - r_last_activity) > r_auto_lock;
    assign hold_done    = (r_in.now_ms - r_hold_start) >= {{(TimeW-HoldW){1'b0}}, r_unlock_hold};
    assign scroll_due   = (r_in.now_ms - r_last_scroll)
                          >= {{(TimeW-ScrollW){1'b0}}, r_scroll_delay};
    assign btn_any      = r_in.btn_up || r_in.btn_down;
    assign btn_both     = r_in.btn_up && r_in.btn_down;
    assign still_unlocked = r_unlock && !idle_expired;

    // step without wrap, clamp high, then below minimum goes to zero
    always_comb begin
        if (r_in.btn_up) begin
            step_sum = $signed({2'b00, r_setpoint}) + $signed({3'b000, r_step});
        end else begin
            step_sum = $signed({2'b00, r_setpoint}) - $signed({3'b000, r_step});
        end
        if (step_sum > $signed({2'b00, r_max_set})) begin
            // the clamped value still has to clear the minimum
            step_result = (r_max_set < r_min_set) ? '0 : r_max_set;
        end else if (step_sum < $signed({2'b00, r_min_set})) begin
            step_result = '0;
        end else begin
            step_result = step_sum[SetW-1:0];
        end
    end

    always_comb begin
        n_unlock        = r_unlock;
        n_last_activity = r_last_activity;
        n_hold_start    = r_hold_start;
        n_last_scroll   = r_last_scroll;
        n_setpoint      = r_setpoint;
        n_adjusted      = 1'b0;
        if (r_in.operation == OpLoad) begin
            n_setpoint = r_in.load_value;
        end else if (!still_unlocked) begin
            n_unlock = 1'b0;
            if (btn_both) begin
                if (r_hold_start == '0) begin
                    n_hold_start = r_in.now_ms;
                end else if (hold_done) begin
                    n_unlock        = 1'b1;
                    n_last_activity = r_in.now_ms;
                    n_hold_start    = '0;
                end
            end else begin
                n_hold_start = '0;
            end
        end else if (btn_any) begin
            n_last_activity = r_in.now_ms;
            if (!btn_both && scroll_due) begin
                n_setpoint    = step_result;
                n_last_scroll = r_in.now_ms;
                n_adjusted    = 1'b1;
            end
        end else begin
            // prime so the next press steps at once
            n_last_scroll = r_in.now_ms - {{(TimeW-ScrollW){1'b0}}, r_scroll_delay};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_unlock        <= 1'b0;
            r_last_activity <= '0;
            r_hold_start    <= '0;
            r_last_scroll   <= '0;
            r_setpoint      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid     <= 1'b1;
                r_unlock        <= n_unlock;
                r_last_activity <= n_last_activity;
                r_hold_start    <= n_hold_start;
                r_last_scroll   <= n_last_scroll;
                r_setpoint      <= n_setpoint;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out.setpoint <= n_setpoint;
            r_out.unlocked <= n_unlock;
            r_out.adjusted <= n_adjusted;
        end
    end

`ifndef SYNTHESIS
    // a step only happens on an unlocked panel
    a_adjust_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.adjusted |-> o_out.unlocked)
        else $error("adjusted word reports a locked panel");

    // no hold is timed while unlocked
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unlock |-> (r_hold_start == '0))
        else $error("hold timer running while unlocked");

    // panel state only moves when a word leaves the input register
    a_state_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_setpoint) && $stable(r_unlock) && $stable(r_last_scroll))
        else $error("panel state changed without a word");

    // result register tracks the state it was written with
    a_out_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.setpoint == r_setpoint) && (r_out.unlocked == r_unlock))
        else $error("result word differs from panel state");
`endif

endmodule
`default_nettype wire

### tb/sv/blsa_panel_checker.sv
// scoreboard for the setpoint panel: tracks the panel state and checks every result word
`timescale 1ns / 1ps
module blsa_panel_checker
    import blsa_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  t_in_word            i_in,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  t_out_word           i_out,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire [CfgIdxW-1:0]   i_cfg_index,
    input  wire [CfgDatW-1:0]   i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // register copies
    logic [HoldW-1:0]   hold_ms;
    logic [TimeW-1:0]   lock_ms;
    logic [ScrollW-1:0] scroll_ms;
    logic [StepW-1:0]   step_deg;
    logic [SetW-1:0]    max_deg;
    logic [SetW-1:0]    min_deg;

    // panel state
    logic               is_unlocked;
    logic [TimeW-1:0]   activity_ms;
    logic [TimeW-1:0]   hold_from_ms;
    logic [TimeW-1:0]   scroll_from_ms;
    logic [SetW-1:0]    setpoint_deg;

    t_out_word panel_expect_q[$];
    int        fail_total = 0;

    // step without wrap, clamp high, then anything below the minimum turns the heater off
    function automatic logic [SetW-1:0] stepped_setpoint(input logic [SetW-1:0] sp,
                                                         input logic up);
        int v;
        v = up ? int'(sp) + int'(step_deg) : int'(sp) - int'(step_deg);
        if (v > int'(max_deg)) v = int'(max_deg);
        if (v < int'(min_deg)) v = 0;
        return SetW'(v);
    endfunction

    task automatic advance_panel(input t_in_word w);
        t_out_word        res;
        logic [TimeW-1:0] now;
        logic             stepped;
        now     = w.now_ms;
        stepped = 1'b0;
        if (w.operation == OpLoad) begin
            setpoint_deg = w.load_value;
        end else begin
            if (is_unlocked && (now - activity_ms) > lock_ms) is_unlocked = 1'b0;
            if (!is_unlocked) begin
                if (w.btn_up && w.btn_down) begin
                    // zero means no hold is being timed
                    if (hold_from_ms == '0) begin
                        hold_from_ms = now;
                    end else if ((now - hold_from_ms) >= hold_ms) begin
                        is_unlocked  = 1'b1;
                        activity_ms  = now;
                        hold_from_ms = '0;
                    end
                end else begin
                    hold_from_ms = '0;
                end
            end else if (w.btn_up || w.btn_down) begin
                activity_ms = now;
                if (!(w.btn_up && w.btn_down) && (now - scroll_from_ms) >= scroll_ms) begin
                    setpoint_deg   = stepped_setpoint(setpoint_deg, w.btn_up);
                    scroll_from_ms = now;
                    stepped        = 1'b1;
                end
            end else begin
                // primed so the next press acts at once
                scroll_from_ms = now - scroll_ms;
            end
        end
        res.setpoint = setpoint_deg;
        res.unlocked = is_unlocked;
        res.adjusted = stepped;
        panel_expect_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (!i_rst_n) begin
            hold_ms        = UnlockHoldRst;
            lock_ms        = AutoLockRst;
            scroll_ms      = ScrollRst;
            step_deg       = StepRst;
            max_deg        = MaxSetRst;
            min_deg        = MinSetRst;
            is_unlocked    = 1'b0;
            activity_ms    = '0;
            hold_from_ms   = '0;
            scroll_from_ms = '0;
            setpoint_deg   = '0;
            panel_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CfgUnlockHold: hold_ms   = i_cfg_data[HoldW-1:0];
                    CfgAutoLock:   lock_ms   = i_cfg_data[TimeW-1:0];
                    CfgScroll:     scroll_ms = i_cfg_data[ScrollW-1:0];
                    CfgStep:       step_deg  = i_cfg_data[StepW-1:0];
                    CfgMaxSet:     max_deg   = i_cfg_data[SetW-1:0];
                    CfgMinSet:     min_deg   = i_cfg_data[SetW-1:0];
                    default: ;
                endcase
            end
            // results first, so a word accepted this edge is never matched against itself
            if (i_out_valid && i_out_ready) begin
                if (panel_expect_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("result word with nothing pending: sp=%0d unl=%0b adj=%0b",
                                 i_out.setpoint, i_out.unlocked, i_out.adjusted);
                    fail_total++;
                end else begin
                    exp_word = panel_expect_q.pop_front();
                    if (i_out.setpoint !== exp_word.setpoint ||
                        i_out.unlocked !== exp_word.unlocked ||
                        i_out.adjusted !== exp_word.adjusted) begin
                        if (fail_total < 10)
                            $display("mismatch: expected sp=%0d unl=%0b adj=%0b, got sp=%0d unl=%0b adj=%0b",
                                     exp_word.setpoint, exp_word.unlocked, exp_word.adjusted,
                                     i_out.setpoint, i_out.unlocked, i_out.adjusted);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) advance_panel(i_in);
        end
        o_pending    <= panel_expect_q.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/sv/button_lock_setpoint_adjuster_top_tb.sv
// testbench top for the setpoint panel: clock, reset, stimulus, register setups and verdict
`timescale 1ns / 1ps
module button_lock_setpoint_adjuster_top_tb;
    import blsa_pkg::*;

    localparam int StallLimit = 4000;
    localparam int LongStall  = 300;
    localparam logic [CfgIdxW-1:0] CfgSpare0 = CfgIdxW'(6);
    localparam logic [CfgIdxW-1:0] CfgSpare1 = CfgIdxW'(7);

    typedef struct {
        logic [CfgIdxW-1:0] idx;
        logic [CfgDatW-1:0] data;
    } t_reg_write;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_word           in_word   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_word          out_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDatW-1:0] cfg_data  = '0;
    int                 fail_count;
    int                 pending;

    t_reg_write  reg_writes[$];
    logic [31:0] clock_ms   = '0;
    int          send_calm  = 0;
    int          stall_asks = 0;

    button_lock_setpoint_adjuster_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    blsa_panel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic t_in_word sample_word(input logic [31:0] now, input logic up,
                                             input logic dn);
        t_in_word w;
        w.operation  = OpSample;
        w.now_ms     = now;
        w.btn_up     = up;
        w.btn_down   = dn;
        w.load_value = SetW'($urandom);
        return w;
    endfunction

    // time and buttons ride along on loads with random content
    function automatic t_in_word load_word(input logic [SetW-1:0] value);
        t_in_word w;
        w.operation  = OpLoad;
        w.now_ms     = $urandom;
        w.btn_up     = 1'($urandom);
        w.btn_down   = 1'($urandom);
        w.load_value = value;
        return w;
    endfunction

    // unused upper data bits get random junk
    function automatic void queue_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value,
                                      input int width);
        t_reg_write wr;
        wr.idx  = idx;
        wr.data = (width < 32) ? (value | (32'($urandom) << width)) : value;
        reg_writes.push_back(wr);
    endfunction

    task automatic offer_word(input t_in_word w);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait until every result word is back
    task automatic settle_panel();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic program_regs();
        t_reg_write wr;
        while (reg_writes.size() > 0) begin
            wr = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.idx;
            cfg_data  <= wr.data;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_words, input int t_hold, input int t_scroll,
                             input logic [31:0] t_idle);
        int   sent;
        int   k;
        logic up;
        logic dn;
        logic dir;
        sent = 0;
        while (sent < n_words) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // both buttons held toward an unlock, now and then broken off
                    k = $urandom_range(2, 8);
                    for (int j = 0; j < k; j++) begin
                        clock_ms += $urandom_range(0, t_hold);
                        {up, dn} = 2'b11;
                        if ($urandom_range(0, 9) == 0) {up, dn} = 2'($urandom_range(0, 2));
                        offer_word(sample_word(clock_ms, up, dn));
                    end
                    sent += k;
                end
                3, 4, 5, 6: begin
                    // one button held for scrolling, with short releases
                    dir = 1'($urandom);
                    k   = $urandom_range(1, 12);
                    for (int j = 0; j < k; j++) begin
                        clock_ms += $urandom_range(0, t_scroll);
                        case ($urandom_range(0, 7))
                            0:       {up, dn} = 2'b00;
                            1:       {up, dn} = 2'b11;
                            default: {up, dn} = {dir, ~dir};
                        endcase
                        offer_word(sample_word(clock_ms, up, dn));
                    end
                    sent += k;
                end
                7: begin
                    offer_word(load_word(SetW'($urandom_range(0, 511))));
                    sent++;
                end
                8: begin
                    // long quiet spell, may run past the auto lock
                    clock_ms += $urandom_range(0, t_idle);
                    offer_word(sample_word(clock_ms, 1'($urandom), 1'($urandom)));
                    sent++;
                end
                default: begin
                    offer_word(sample_word($urandom, 1'($urandom), 1'($urandom)));
                    sent++;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int hold;
        int lock;
        int scroll;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on the reset settings
        offer_word(sample_word(32'd0, 1'b1, 1'b1));       // hold at time zero is not timed
        offer_word(sample_word(32'd5, 1'b1, 1'b1));
        offer_word(sample_word(32'd3004, 1'b1, 1'b1));    // one ms short
        offer_word(sample_word(32'd3005, 1'b1, 1'b1));    // unlocks, no step
        offer_word(load_word(SetW'(511)));                // loads are not clamped
        offer_word(sample_word(32'd3010, 1'b1, 1'b0));    // clamps to max
        offer_word(sample_word(32'd3011, 1'b1, 1'b0));    // inside scroll delay
        offer_word(sample_word(32'd3012, 1'b0, 1'b0));    // primes scroll timer
        offer_word(sample_word(32'd3012, 1'b0, 1'b1));    // acts at once
        offer_word(load_word(SetW'(151)));
        offer_word(sample_word(32'd4000, 1'b0, 1'b1));    // drops below min
        offer_word(load_word(SetW'(0)));
        offer_word(sample_word(32'd5000, 1'b0, 1'b1));    // negative difference
        offer_word(sample_word(32'd5001, 1'b1, 1'b1));    // both pressed while unlocked
        offer_word(sample_word(32'd65001, 1'b1, 1'b0));   // exactly the lock limit
        offer_word(sample_word(32'd125002, 1'b0, 1'b0));  // one past it: locks
        offer_word(sample_word(32'hFFFF_FFF0, 1'b1, 1'b1));
        offer_word(sample_word(32'h0000_0BB0, 1'b1, 1'b1)); // hold across the wrap
        offer_word(sample_word(32'hFFFF_FFFF, 1'b0, 1'b1));

        run_phase(262, 1200, 300, 32'd130000);

        // everything at its lowest
        settle_panel();
        queue_reg(CfgUnlockHold, 32'd0, HoldW);
        queue_reg(CfgAutoLock, 32'd0, TimeW);
        queue_reg(CfgScroll, 32'd0, ScrollW);
        queue_reg(CfgStep, 32'd0, StepW);
        queue_reg(CfgMaxSet, 32'd0, SetW);
        queue_reg(CfgMinSet, 32'd0, SetW);
        program_regs();
        run_phase(262, 2, 2, 32'd3);

        // everything at its highest
        settle_panel();
        queue_reg(CfgUnlockHold, 32'd65535, HoldW);
        queue_reg(CfgAutoLock, 32'hFFFF_FFFF, TimeW);
        queue_reg(CfgScroll, 32'd65535, ScrollW);
        queue_reg(CfgStep, 32'd255, StepW);
        queue_reg(CfgMaxSet, 32'd511, SetW);
        queue_reg(CfgMinSet, 32'd511, SetW);
        program_regs();
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
        run_phase(262, 30000, 40000, 32'hFFFF_FFFF);

        // max below min: every step lands on zero
        settle_panel();
        queue_reg(CfgUnlockHold, 32'd10, HoldW);
        queue_reg(CfgAutoLock, 32'd50, TimeW);
        queue_reg(CfgScroll, 32'd3, ScrollW);
        queue_reg(CfgStep, 32'd7, StepW);
        queue_reg(CfgMaxSet, 32'd100, SetW);
        queue_reg(CfgMinSet, 32'd300, SetW);
        program_regs();
        run_phase(262, 6, 5, 32'd100);

        for (int p = 0; p < 3; p++) begin
            hold   = $urandom_range(0, 40);
            lock   = $urandom_range(20, 400);
            scroll = $urandom_range(0, 15);
            settle_panel();
            queue_reg(CfgUnlockHold, 32'(hold), HoldW);
            queue_reg(CfgAutoLock, 32'(lock), TimeW);
            queue_reg(CfgScroll, 32'(scroll), ScrollW);
            queue_reg(CfgStep, 32'($urandom_range(1, 20)), StepW);
            queue_reg(CfgMaxSet, 32'($urandom_range(200, 511)), SetW);
            queue_reg(CfgMinSet, 32'($urandom_range(0, 200)), SetW);
            if (p == 1) begin
                // writes past the last register must change nothing
                queue_reg(CfgSpare0, $urandom, CfgDatW);
                queue_reg(CfgSpare1, $urandom, CfgDatW);
            end
            if (p == 0) stall_asks++;
            program_regs();
            if ($urandom_range(0, 1) == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
            run_phase(262, hold / 3 + 1, scroll + 3, 32'(2 * lock));
        end

        settle_panel();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("button_lock_setpoint_adjuster_top verification clean");
        end else begin
            $display("button_lock_setpoint_adjuster_top verification failed");
        end
        $finish;
    end

    initial begin : drain
        int hold_off;
        int calm;
        int served;
        calm   = 0;
        served = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (stall_asks != served) begin
                // long back-pressure so the pipe fills and input ready drops
                served   = stall_asks;
                hold_off = LongStall;
            end else if (calm > 0) begin
                calm--;
                hold_off = 0;
            end else begin
                hold_off = $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
            end
            if (hold_off > 0) begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit) begin
                $display("button_lock_setpoint_adjuster_top verification failed");
                $finish;
            end
        end
    end

endmodule

### sim.f
hdl/blsa_pkg.sv
hdl/button_lock_setpoint_adjuster_top.sv
tb/sv/blsa_panel_checker.sv
tb/sv/button_lock_setpoint_adjuster_top_tb.sv
